// File: rtl/tfcg_pkg.sv
// Package for the trigger/fire coincidence gate: types, codes, widths and reset values.
package tfcg_pkg;

  // Default width of stored timestamps
  localparam int TIME_BITS_DEF = 48;

  // Payload field widths
  localparam int LEVEL_W = 8;
  localparam int TS_W    = 48;
  localparam int OBJ_W   = 64;
  localparam int WIN_W   = 20;
  localparam int AGE_W   = 20;

  // Stream widths (tdata padded to whole bytes)
  localparam int IN_FIELDS_W  = LEVEL_W + TS_W + OBJ_W + 3;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 + OBJ_W + AGE_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = WIN_W;

  // Register reset values
  localparam logic [LEVEL_W-1:0] PRESS_THRESHOLD_RST = 8'd24;
  localparam logic [WIN_W-1:0]   MAX_PRE_AGE_RST     = 20'd100000;
  localparam logic [WIN_W-1:0]   MAX_POST_SKEW_RST   = 20'd20000;
  localparam logic [WIN_W-1:0]   DUP_WINDOW_RST      = 20'd20000;
  localparam logic [WIN_W-1:0]   FWD_WINDOW_RST      = 20'd180000;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_TRIGGER = 2'd0,
    CMD_FIRE    = 2'd1,
    CMD_PILOT   = 2'd2,
    CMD_MENU    = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PRESS_THRESHOLD = 3'd0,
    REG_MAX_PRE_AGE     = 3'd1,
    REG_MAX_POST_SKEW   = 3'd2,
    REG_DUP_WINDOW      = 3'd3,
    REG_FWD_WINDOW      = 3'd4
  } reg_idx_t;

endpackage

// File: rtl/trigger_fire_coincidence_gate_top.sv
// Trigger/fire coincidence gate: input register, combinational decision with registered state update, result register.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+---------------------------------------------
//  s_axis  | in  | s_axis_tvalid/tready    | tuser: command; tdata: level, time, object, flags
//  m_axis  | out | m_axis_tvalid/tready    | tdata: fire_authorized, deferred_fire, object, age
//  cfg     | in  | cfg_we                  | cfg_addr: register index; cfg_data: value
//
// One beat in and one beat out per cycle, sustained while m_axis_tready stays high. A beat is
// captured in the input register, decided and applied to the state when it advances to the
// result register, and shown from there. The state update and the result load share that advance.
// rst clears all control state and restores the register defaults. A stalled m_axis holds
// the result and the input register; s_axis_tready drops only when both are full.
module trigger_fire_coincidence_gate_top
  import tfcg_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // slave stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] trigger_level, [55:8] timestamp_us, [119:56] object_id,
  // [120] semantic_match, [121] hardware_alias, [122] flag_value, [127:123] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] command
  input  logic [1:0]            s_axis_tuser,
  // master stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] fire_authorized, [1] deferred_fire, [65:2] deferred_object_id,
  // [85:66] deferred_age_us, [87:86] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TW = TIME_BITS;

  // configuration registers
  logic [LEVEL_W-1:0] press_threshold;
  logic [WIN_W-1:0]   max_pre_age;
  logic [WIN_W-1:0]   max_post_skew;
  logic [WIN_W-1:0]   dup_window;
  logic [WIN_W-1:0]   fwd_window;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold <= PRESS_THRESHOLD_RST;
      max_pre_age     <= MAX_PRE_AGE_RST;
      max_post_skew   <= MAX_POST_SKEW_RST;
      dup_window      <= DUP_WINDOW_RST;
      fwd_window      <= FWD_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_PRESS_THRESHOLD: press_threshold <= cfg_data[LEVEL_W-1:0];
        REG_MAX_PRE_AGE:     max_pre_age     <= cfg_data;
        REG_MAX_POST_SKEW:   max_post_skew   <= cfg_data;
        REG_DUP_WINDOW:      dup_window      <= cfg_data;
        REG_FWD_WINDOW:      fwd_window      <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: advance when the result register is free or being emptied
  logic in_v;
  logic out_v;
  logic adv;
  logic go;

  assign adv           = !out_v || m_axis_tready;
  assign go            = in_v && adv;
  assign s_axis_tready = !in_v || adv;
  assign m_axis_tvalid = out_v;

  // input register
  cmd_t               in_cmd;
  logic [LEVEL_W-1:0] in_level;
  logic [TS_W-1:0]    in_ts;
  logic [OBJ_W-1:0]   in_obj;
  logic               in_sem;
  logic               in_alias;
  logic               in_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_axis_tready) begin
      in_v <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd   <= cmd_t'(s_axis_tuser);
      in_level <= s_axis_tdata[7:0];
      in_ts    <= s_axis_tdata[55:8];
      in_obj   <= s_axis_tdata[119:56];
      in_sem   <= s_axis_tdata[120];
      in_alias <= s_axis_tdata[121];
      in_flag  <= s_axis_tdata[122];
    end
  end

  // gate state
  logic               pilot_on, pilot_on_next;
  logic               menu_on, menu_on_next;
  logic [LEVEL_W-1:0] current_level, current_level_next;
  logic [TW-1:0]      last_press_time, last_press_time_next;
  logic [TW-1:0]      last_auth_time, last_auth_time_next;
  logic               stream_armed, stream_armed_next;
  logic [OBJ_W-1:0]   stream_object, stream_object_next;
  logic [TW-1:0]      pending_time, pending_time_next;
  logic [OBJ_W-1:0]   pending_object, pending_object_next;

  // result of the current beat
  logic               res_fire;
  logic               res_def;
  logic [OBJ_W-1:0]   res_obj;
  logic [AGE_W-1:0]   res_age;

  // shared time arithmetic
  logic [TW-1:0] t;
  logic [TW-1:0] d_auth;
  logic [TW-1:0] d_press;
  logic [TW-1:0] d_press_rev;
  logic [TW-1:0] d_pend;
  logic          active;
  logic          held;
  logic          claim_ok;
  logic          pend_live;
  logic          out_of_window;

  assign t           = TW'(in_ts);
  assign d_auth      = t - last_auth_time;
  assign d_press     = t - last_press_time;
  assign d_press_rev = last_press_time - t;
  assign d_pend      = t - pending_time;
  assign active      = pilot_on && !menu_on;
  assign held        = current_level >= press_threshold;

  // duplicate suppression: recent authorized fire at or before t blocks
  assign claim_ok = !((last_auth_time != '0) && (t >= last_auth_time)
                      && (d_auth < TW'(dup_window)));
  // t lies within the forward window after the pending shot
  assign pend_live = (t >= pending_time) && (d_pend <= TW'(fwd_window));
  assign out_of_window = (t >= last_press_time) ? (d_press > TW'(max_pre_age))
                                                : (d_press_rev > TW'(max_post_skew));

  // decision and state update
  always_comb begin
    pilot_on_next        = pilot_on;
    menu_on_next         = menu_on;
    current_level_next   = current_level;
    last_press_time_next = last_press_time;
    last_auth_time_next  = last_auth_time;
    stream_armed_next    = stream_armed;
    stream_object_next   = stream_object;
    pending_time_next    = pending_time;
    pending_object_next  = pending_object;
    res_fire             = 1'b0;
    res_def              = 1'b0;
    res_obj              = '0;
    res_age              = '0;

    case (in_cmd)
      CMD_TRIGGER: begin
        if (active) begin
          current_level_next = in_level;
          if (in_level < press_threshold) begin
            // release: drop stream and duplicate tracking, a press-to-release clears the pending shot
            last_auth_time_next = '0;
            stream_armed_next   = 1'b0;
            stream_object_next  = '0;
            if (held) begin
              pending_time_next   = '0;
              pending_object_next = '0;
            end
          end else begin
            last_press_time_next = t;
            if (pending_time != '0) begin
              pending_time_next   = '0;
              pending_object_next = '0;
              if (pend_live) begin
                // deferred first shot
                res_def             = 1'b1;
                res_obj             = pending_object;
                res_age             = d_pend[AGE_W-1:0];
                last_auth_time_next = pending_time;
                stream_object_next  = pending_object;
                stream_armed_next   = 1'b1;
              end
            end
          end
        end
      end
      CMD_FIRE: begin
        if (active && (in_sem || in_alias)) begin
          if (in_alias && held && stream_armed) begin
            // automatic stream bound to one object
            if ((stream_object == in_obj) && claim_ok) begin
              res_fire            = 1'b1;
              last_auth_time_next = t;
              pending_time_next   = '0;
              pending_object_next = '0;
            end
          end else if ((last_press_time == '0) || out_of_window) begin
            // no usable press: keep as pending first shot unless one is still live
            if (in_alias && !held && !((pending_time != '0) && pend_live)) begin
              pending_time_next   = t;
              pending_object_next = in_obj;
            end
          end else if (claim_ok) begin
            res_fire            = 1'b1;
            last_auth_time_next = t;
            pending_time_next   = '0;
            pending_object_next = '0;
            if (in_alias && held) begin
              stream_object_next = in_obj;
              stream_armed_next  = 1'b1;
            end
          end
        end
      end
      CMD_PILOT: begin
        pilot_on_next = in_flag;
        if (!in_flag || !pilot_on) begin
          pending_time_next    = '0;
          pending_object_next  = '0;
          current_level_next   = '0;
          last_press_time_next = '0;
          last_auth_time_next  = '0;
          stream_armed_next    = 1'b0;
          stream_object_next   = '0;
        end
      end
      default: begin
        // menu block
        menu_on_next = in_flag;
        if (menu_on != in_flag) begin
          pending_time_next   = '0;
          pending_object_next = '0;
        end
        if (in_flag) begin
          current_level_next   = '0;
          last_press_time_next = '0;
          last_auth_time_next  = '0;
          stream_armed_next    = 1'b0;
          stream_object_next   = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pilot_on        <= 1'b0;
      menu_on         <= 1'b0;
      current_level   <= '0;
      last_press_time <= '0;
      last_auth_time  <= '0;
      stream_armed    <= 1'b0;
      stream_object   <= '0;
      pending_time    <= '0;
      pending_object  <= '0;
    end else if (go) begin
      pilot_on        <= pilot_on_next;
      menu_on         <= menu_on_next;
      current_level   <= current_level_next;
      last_press_time <= last_press_time_next;
      last_auth_time  <= last_auth_time_next;
      stream_armed    <= stream_armed_next;
      stream_object   <= stream_object_next;
      pending_time    <= pending_time_next;
      pending_object  <= pending_object_next;
    end
  end

  // result register
  logic             out_fire;
  logic             out_def;
  logic [OBJ_W-1:0] out_obj;
  logic [AGE_W-1:0] out_age;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_fire <= res_fire;
      out_def  <= res_def;
      out_obj  <= res_obj;
      out_age  <= res_age;
    end
  end

  assign m_axis_tdata = {(OUT_DATA_W - OUT_FIELDS_W)'(0), out_age, out_obj, out_def, out_fire};

endmodule

// File: dv/tb.sv
// Self-checking testbench for the trigger/fire coincidence gate: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
  import tfcg_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES = 6;
  localparam int BEATS_PER_PHASE = 285;

  // One input beat, fields as the block sees them
  typedef struct {
    cmd_t             cmd;
    logic [LEVEL_W-1:0] level;
    logic [TS_W-1:0]  ts;
    logic [OBJ_W-1:0] obj;
    logic             sem;
    logic             hw_alias;
    logic             flag;
  } beat_t;

  // One result beat
  typedef struct packed {
    logic             fire;
    logic             dfire;
    logic [OBJ_W-1:0] dobj;
    logic [AGE_W-1:0] dage;
  } verdict_t;

  // Directed row: beat plus an optional typed-in verdict
  typedef struct {
    beat_t    b;
    logic     typed;
    verdict_t v;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  trigger_fire_coincidence_gate_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Gate shadow: settings
  logic [LEVEL_W-1:0] c_thresh;
  logic [WIN_W-1:0]   c_pre, c_post, c_dup, c_fwd;
  // Gate shadow: tracking and pending first shot
  logic               g_pilot, g_menu, g_stream_on;
  logic [LEVEL_W-1:0] g_level;
  logic [TS_W-1:0]    g_press_ts, g_auth_ts, g_pend_ts;
  logic [OBJ_W-1:0]   g_stream_obj, g_pend_obj;

  verdict_t verdict_q[$];
  int       mismatches = 0;
  int       src_idle_pct = 0;
  int       snk_idle_pct = 0;
  int       n_beats = 0;
  int       n_auth = 0;
  int       n_deferred = 0;
  int       quiet_cycles = 0;

  function automatic void drop_pending();
    g_pend_ts = '0;
    g_pend_obj = '0;
  endfunction

  function automatic void drop_tracking();
    g_level = '0;
    g_press_ts = '0;
    g_auth_ts = '0;
    g_stream_on = 1'b0;
    g_stream_obj = '0;
  endfunction

  function automatic void gate_reset();
    c_thresh = PRESS_THRESHOLD_RST;
    c_pre = MAX_PRE_AGE_RST;
    c_post = MAX_POST_SKEW_RST;
    c_dup = DUP_WINDOW_RST;
    c_fwd = FWD_WINDOW_RST;
    g_pilot = 1'b0;
    g_menu = 1'b0;
    drop_pending();
    drop_tracking();
  endfunction

  // t lies at or after base_ts and no further than lim
  function automatic logic ahead(logic [TS_W-1:0] t, logic [TS_W-1:0] base_ts,
                                 logic [WIN_W-1:0] lim);
    return (t >= base_ts) && ((t - base_ts) <= lim);
  endfunction

  // Duplicate suppression; records the fire time when it passes
  function automatic logic claim_fire(logic [TS_W-1:0] t);
    if (g_auth_ts != 0 && t >= g_auth_ts && (t - g_auth_ts) < c_dup) return 1'b0;
    g_auth_ts = t;
    return 1'b1;
  endfunction

  // Keep an early alias fire as the first shot, unless one is still live
  function automatic void hold_first_shot(logic [OBJ_W-1:0] obj, logic [TS_W-1:0] t);
    if (g_level >= c_thresh) return;
    if (g_pend_ts != 0 && ahead(t, g_pend_ts, c_fwd)) return;
    g_pend_ts = t;
    g_pend_obj = obj;
  endfunction

  function automatic logic fire_ok(beat_t b);
    logic held;
    logic late;
    if (!g_pilot || g_menu || !(b.sem || b.hw_alias)) return 1'b0;
    held = (g_level >= c_thresh);
    // armed auto-fire stream: only its own object, duplicate rule still applies
    if (b.hw_alias && held && g_stream_on) begin
      if (g_stream_obj != b.obj) return 1'b0;
      if (!claim_fire(b.ts)) return 1'b0;
      drop_pending();
      return 1'b1;
    end
    if (g_press_ts == 0) begin
      if (b.hw_alias && !held) hold_first_shot(b.obj, b.ts);
      return 1'b0;
    end
    late = (b.ts >= g_press_ts) ? ((b.ts - g_press_ts) > c_pre)
                                : ((g_press_ts - b.ts) > c_post);
    if (late) begin
      if (b.hw_alias && !held) hold_first_shot(b.obj, b.ts);
      return 1'b0;
    end
    if (!claim_fire(b.ts)) return 1'b0;
    drop_pending();
    if (b.hw_alias && held) begin
      g_stream_obj = b.obj;
      g_stream_on = 1'b1;
    end
    return 1'b1;
  endfunction

  // Expected result of one beat; advances the shadow state
  function automatic verdict_t decide_beat(beat_t b);
    verdict_t           v;
    logic [LEVEL_W-1:0] prev_lvl;
    logic               prev;
    logic [TS_W-1:0]    age;
    v = '0;
    case (b.cmd)
      CMD_TRIGGER: begin
        if (g_pilot && !g_menu) begin
          prev_lvl = g_level;
          g_level = b.level;
          if (b.level < c_thresh) begin
            // release: stream and duplicate tracking drop
            g_auth_ts = '0;
            g_stream_on = 1'b0;
            g_stream_obj = '0;
            if (prev_lvl >= c_thresh) drop_pending();
          end else begin
            g_press_ts = b.ts;
            if (g_pend_ts != 0) begin
              if (!ahead(b.ts, g_pend_ts, c_fwd)) begin
                drop_pending();
              end else begin
                // press releases the pending first shot
                age = b.ts - g_pend_ts;
                v.dfire = 1'b1;
                v.dobj = g_pend_obj;
                v.dage = age[AGE_W-1:0];
                g_auth_ts = g_pend_ts;
                g_stream_obj = g_pend_obj;
                g_stream_on = 1'b1;
                drop_pending();
              end
            end
          end
        end
      end
      CMD_FIRE: v.fire = fire_ok(b);
      CMD_PILOT: begin
        prev = g_pilot;
        g_pilot = b.flag;
        if (!b.flag || !prev) begin
          drop_pending();
          drop_tracking();
        end
      end
      default: begin
        prev = g_menu;
        g_menu = b.flag;
        if (prev != b.flag) drop_pending();
        if (b.flag) drop_tracking();
      end
    endcase
    return v;
  endfunction

  // Offer one beat, wait for the handshake, then queue its expected result
  task automatic push_beat(input beat_t b, input logic typed, input verdict_t typed_v);
    verdict_t v;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, b.flag, b.hw_alias, b.sem, b.obj, b.ts, b.level};
    s_axis_tuser <= b.cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    v = decide_beat(b);
    if (typed) v = typed_v;
    verdict_q.push_back(v);
    n_beats++;
    if (v.fire) n_auth++;
    if (v.dfire) n_deferred++;
  endtask

  // Hold the sender off until every expected beat is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: check each beat, randomize backpressure
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        $error("result beat with nothing expected: 0x%0h", m_axis_tdata);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        check_field("fire_authorized", 64'(want.fire), 64'(m_axis_tdata[0]));
        check_field("deferred_fire", 64'(want.dfire), 64'(m_axis_tdata[1]));
        check_field("deferred_object_id", want.dobj, m_axis_tdata[65:2]);
        check_field("deferred_age_us", 64'(want.dage), 64'(m_axis_tdata[85:66]));
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Directed row helper
  dir_row_t dir_rows[$];

  function automatic void add_row(cmd_t cmd, logic [7:0] level, logic [47:0] ts,
                                  logic [63:0] obj, logic sem, logic hw, logic flag,
                                  logic typed, verdict_t v);
    dir_row_t r;
    r.b.cmd = cmd;
    r.b.level = level;
    r.b.ts = ts;
    r.b.obj = obj;
    r.b.sem = sem;
    r.b.hw_alias = hw;
    r.b.flag = flag;
    r.typed = typed;
    r.v = v;
    dir_rows.push_back(r);
  endfunction

  // Random beat generator state
  logic [TS_W-1:0]  now_ts;
  logic [OBJ_W-1:0] obj_pool[3];

  function automatic beat_t next_beat();
    beat_t       b;
    logic [63:0] r64;
    int          span;
    int          pick;
    int          thr;
    span = (int'(c_pre) + int'(c_post) + int'(c_fwd)) / 3 + 64;
    thr = int'(c_thresh);
    r64 = {$urandom(), $urandom()};
    b.ts = r64[TS_W-1:0];
    b.obj = {$urandom(), $urandom()};
    b.level = LEVEL_W'($urandom_range(0, 255));
    b.sem = 1'($urandom_range(0, 1));
    b.hw_alias = 1'($urandom_range(0, 1));
    b.flag = 1'($urandom_range(0, 1));
    b.cmd = cmd_t'($urandom_range(0, 3));
    // a few fully random beats as noise
    if ($urandom_range(0, 99) < 6) return b;
    // time mostly creeps forward, sometimes stands, steps back or jumps
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
    end else if (pick < 15) begin
      now_ts -= TS_W'($urandom_range(0, span / 4));
    end else if (pick < 18) begin
      now_ts = b.ts;
    end else begin
      now_ts += TS_W'($urandom_range(0, span));
    end
    b.ts = now_ts;
    pick = $urandom_range(0, 99);
    if (pick < 42) b.cmd = CMD_TRIGGER;
    else if (pick < 90) b.cmd = CMD_FIRE;
    else if (pick < 95) b.cmd = CMD_PILOT;
    else b.cmd = CMD_MENU;
    if (b.cmd == CMD_PILOT) b.flag = ($urandom_range(0, 99) >= 10);
    if (b.cmd == CMD_MENU) b.flag = ($urandom_range(0, 99) < 10);
    // levels cluster on either side of the threshold
    pick = $urandom_range(0, 99);
    if (pick < 35 && thr > 0) b.level = LEVEL_W'($urandom_range(0, thr - 1));
    else if (pick < 70) b.level = LEVEL_W'($urandom_range(thr, 255));
    if ($urandom_range(0, 99) < 75) b.obj = obj_pool[$urandom_range(0, 2)];
    b.sem = ($urandom_range(0, 99) < 55);
    b.hw_alias = ($urandom_range(0, 99) < 60);
    return b;
  endfunction

  // Register settings per random phase, in index order
  reg_idx_t    reg_order[5] = '{REG_PRESS_THRESHOLD, REG_MAX_PRE_AGE, REG_MAX_POST_SKEW,
                                REG_DUP_WINDOW, REG_FWD_WINDOW};
  logic [19:0] phase_cfg[PHASES][5];

  task automatic load_settings(input int ph);
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= reg_order[i];
      cfg_data <= phase_cfg[ph][i];
      @(posedge clk);
      case (reg_order[i])
        REG_PRESS_THRESHOLD: c_thresh = phase_cfg[ph][i][LEVEL_W-1:0];
        REG_MAX_PRE_AGE:     c_pre = phase_cfg[ph][i];
        REG_MAX_POST_SKEW:   c_post = phase_cfg[ph][i];
        REG_DUP_WINDOW:      c_dup = phase_cfg[ph][i];
        default:             c_fwd = phase_cfg[ph][i];
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    verdict_t    z;
    verdict_t    first_shot;
    beat_t       b;
    logic [63:0] r64;

    z = '0;
    first_shot = '0;
    first_shot.dfire = 1'b1;
    first_shot.dobj = 64'hA5A5_0F0F_3C3C_9696;
    first_shot.dage = 20'd4000;

    // extremes: all-open, all-shut, wide, two random, defaults
    phase_cfg[0] = '{20'd0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF};
    phase_cfg[1] = '{20'd255, 20'd0, 20'd0, 20'd0, 20'd0};
    phase_cfg[2] = '{20'd128, 20'd1000000, 20'd1000000, 20'd1, 20'd1000000};
    phase_cfg[4] = '{20'd24, 20'd100000, 20'd20000, 20'd20000, 20'd180000};
    for (int ph = 3; ph < PHASES; ph += 2) begin
      phase_cfg[ph][0] = 20'($urandom_range(1, 254));
      for (int i = 1; i < 5; i++) phase_cfg[ph][i] = 20'($urandom_range(0, 200000));
    end

    // inactive, pending first shot, deferred release, stream, skew, blocking, zero time
    add_row(CMD_FIRE,    8'd0,   48'd100,   64'd0, 1'b1, 1'b1, 1'b0, 1'b1, z);
    add_row(CMD_TRIGGER, 8'd255, 48'd200,   64'd0, 1'b0, 1'b0, 1'b0, 1'b1, z);
    add_row(CMD_PILOT,   8'd0,   48'd300,   64'd0, 1'b0, 1'b0, 1'b1, 1'b1, z);
    add_row(CMD_FIRE,    8'd0,   48'd1000,  64'hA5A5_0F0F_3C3C_9696,
            1'b0, 1'b1, 1'b0, 1'b1, z);
    add_row(CMD_TRIGGER, 8'd255, 48'd5000,  64'd0, 1'b0, 1'b0, 1'b0, 1'b1, first_shot);
    add_row(CMD_FIRE,    8'd0,   48'd30000, 64'hA5A5_0F0F_3C3C_9696,
            1'b0, 1'b1, 1'b0, 1'b0, z);
    add_row(CMD_FIRE,    8'd0,   48'd60000, 64'hFFFF_FFFF_FFFF_FFFF,
            1'b0, 1'b1, 1'b0, 1'b0, z);
    add_row(CMD_FIRE,    8'd0,   48'd30005, 64'd0, 1'b1, 1'b0, 1'b0, 1'b0, z);
    add_row(CMD_FIRE,    8'd0,   48'd40000, 64'd0, 1'b0, 1'b0, 1'b0, 1'b1, z);
    add_row(CMD_TRIGGER, 8'd0,   48'd50000, 64'd0, 1'b0, 1'b0, 1'b0, 1'b1, z);
    add_row(CMD_FIRE,    8'd0,   48'd1,     64'd7, 1'b1, 1'b0, 1'b0, 1'b0, z);
    add_row(CMD_FIRE,    8'd0,   48'hFFFF_FFFF_FFFF, 64'd7, 1'b1, 1'b0, 1'b0, 1'b0, z);
    add_row(CMD_MENU,    8'd0,   48'd60000, 64'd0, 1'b0, 1'b0, 1'b1, 1'b1, z);
    add_row(CMD_TRIGGER, 8'd255, 48'd70000, 64'd0, 1'b0, 1'b0, 1'b0, 1'b1, z);
    add_row(CMD_FIRE,    8'd0,   48'd70001, 64'd0, 1'b1, 1'b1, 1'b0, 1'b1, z);
    add_row(CMD_MENU,    8'd0,   48'd70002, 64'd0, 1'b0, 1'b0, 1'b0, 1'b1, z);
    add_row(CMD_TRIGGER, 8'd24,  48'd0,     64'd0, 1'b0, 1'b0, 1'b0, 1'b1, z);
    add_row(CMD_FIRE,    8'd0,   48'd10,    64'd0, 1'b1, 1'b0, 1'b0, 1'b0, z);
    add_row(CMD_TRIGGER, 8'd23,  48'd80000, 64'd0, 1'b0, 1'b0, 1'b0, 1'b1, z);
    add_row(CMD_FIRE,    8'd0,   48'd0,     64'hFFFF_FFFF_FFFF_FFFF,
            1'b0, 1'b1, 1'b0, 1'b0, z);
    add_row(CMD_FIRE,    8'd0,   48'd90000, 64'd1, 1'b0, 1'b1, 1'b0, 1'b0, z);
    add_row(CMD_PILOT,   8'd0,   48'd91000, 64'd0, 1'b0, 1'b0, 1'b1, 1'b1, z);
    add_row(CMD_TRIGGER, 8'd200, 48'd95000, 64'd0, 1'b0, 1'b0, 1'b0, 1'b0, z);
    add_row(CMD_PILOT,   8'd0,   48'd95500, 64'd0, 1'b0, 1'b0, 1'b0, 1'b1, z);
    add_row(CMD_TRIGGER, 8'd255, 48'd96000, 64'd0, 1'b0, 1'b0, 1'b0, 1'b1, z);

    gate_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table with light idling
    src_idle_pct = 27;
    snk_idle_pct = 68;
    foreach (dir_rows[i]) push_beat(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].v);

    // random phases, one register setting each
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      repeat (SETTLE_CYCLES) @(posedge clk);
      load_settings(ph);
      if (ph < 2) begin
        src_idle_pct = 27;
        snk_idle_pct = 68;
      end else if (ph < 4) begin
        src_idle_pct = 68;
        snk_idle_pct = 27;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      r64 = {$urandom(), $urandom()};
      now_ts = r64[TS_W-1:0];
      for (int i = 0; i < 3; i++) obj_pool[i] = {$urandom(), $urandom()};

      // bring the gate up: pilot on, menu clear
      b = next_beat();
      b.cmd = CMD_PILOT;
      b.flag = 1'b1;
      push_beat(b, 1'b0, z);
      b.cmd = CMD_MENU;
      b.flag = 1'b0;
      push_beat(b, 1'b0, z);

      for (int i = 0; i < BEATS_PER_PHASE; i++) begin
        b = next_beat();
        push_beat(b, 1'b0, z);
        // sender holds off mid-phase until everything is back
        if (i == BEATS_PER_PHASE / 2) drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0) mismatches++;

    $display("Covered %0d beats: directed table plus %0d register settings from shut to open,",
             n_beats, PHASES);
    $display("with %0d fires authorized and %0d pending first shots released by a press.",
             n_auth, n_deferred);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
